[src/rss_pkg.sv]
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, widths and the control program of the record selection sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int SCORE_W         = 10;
  localparam int IDENT_W         = 18;
  localparam int REC_W           = SCORE_W + IDENT_W;

  // Datapath operation selected by the current control word.
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_INIT,
    OP_READ_POS,
    OP_TAKE_POS,
    OP_READ_SCAN,
    OP_COMPARE,
    OP_WRITE_POS,
    OP_WRITE_BEST,
    OP_EMIT_INIT,
    OP_EMIT_READ,
    OP_EMIT_OUT,
    OP_CLEAR
  } op_t;

  // Jump condition: when true the step counter loads the target, else it advances.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_WAIT_CLOSE,
    COND_FEW,
    COND_SCAN_MORE,
    COND_POS_MORE,
    COND_OUT_BUSY,
    COND_K_MORE
  } cond_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_P0,
    ST_P1,
    ST_SREAD,
    ST_SCMP,
    ST_SW0,
    ST_SW1,
    ST_E0,
    ST_EREAD,
    ST_EOUT,
    ST_DONE
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_close;
    logic few;
    logic scan_more;
    logic pos_more;
    logic k_more;
    logic out_busy;
  } status_t;

  // The control program, one word per step.
  function automatic ctrl_t microcode(step_t step);
    ctrl_t w;
    begin
      case (step)
        ST_LOAD:  w = '{OP_LOAD,       COND_WAIT_CLOSE, ST_LOAD};
        ST_INIT:  w = '{OP_INIT,       COND_FEW,        ST_E0};
        ST_P0:    w = '{OP_READ_POS,   COND_NEXT,       ST_P0};
        ST_P1:    w = '{OP_TAKE_POS,   COND_NEXT,       ST_P1};
        ST_SREAD: w = '{OP_READ_SCAN,  COND_NEXT,       ST_SREAD};
        ST_SCMP:  w = '{OP_COMPARE,    COND_SCAN_MORE,  ST_SREAD};
        ST_SW0:   w = '{OP_WRITE_POS,  COND_NEXT,       ST_SW0};
        ST_SW1:   w = '{OP_WRITE_BEST, COND_POS_MORE,   ST_P0};
        ST_E0:    w = '{OP_EMIT_INIT,  COND_NEXT,       ST_E0};
        ST_EREAD: w = '{OP_EMIT_READ,  COND_OUT_BUSY,   ST_EREAD};
        ST_EOUT:  w = '{OP_EMIT_OUT,   COND_K_MORE,     ST_EREAD};
        ST_DONE:  w = '{OP_CLEAR,      COND_JUMP,       ST_LOAD};
        default:  w = '{OP_CLEAR,      COND_JUMP,       ST_LOAD};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

[src/rss_sequencer.sv]
// ----------------------------------------------------------------------------
// rss_sequencer
// Step counter with the control program table and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_sequencer
  import rss_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t stat,
  output ctrl_t        ctrl
);

  step_t upc;
  step_t upc_next;
  logic  take;

  always_comb begin
    ctrl = microcode(upc);
  end

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:       take = 1'b0;
      COND_JUMP:       take = 1'b1;
      COND_WAIT_CLOSE: take = !stat.in_close;
      COND_FEW:        take = stat.few;
      COND_SCAN_MORE:  take = stat.scan_more;
      COND_POS_MORE:   take = stat.pos_more;
      COND_OUT_BUSY:   take = stat.out_busy;
      COND_K_MORE:     take = stat.k_more;
      default:         take = 1'b1;
    endcase
    upc_next = take ? ctrl.target : step_t'(4'(upc) + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_LOAD;
    end else begin
      upc <= upc_next;
    end
  end

  // Loading only ends on the transfer that closes a set.
  a_load_holds: assert property (@(posedge clk) disable iff (rst)
    (upc == ST_LOAD && !stat.in_close) |=> (upc == ST_LOAD))
    else $error("sequencer left loading without a closing transfer");

  // A pass ends only after its scan reached the end of the set.
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (upc == ST_SCMP && !stat.scan_more) |=> (upc == ST_SW0))
    else $error("scan loop exit went astray");

  // The emit read waits while the previous result is still held.
  a_emit_wait: assert property (@(posedge clk) disable iff (rst)
    (upc == ST_EREAD && stat.out_busy) |=> (upc == ST_EREAD))
    else $error("emit step moved on while the output was stalled");

endmodule

`default_nettype wire

[src/rss_datapath.sv]
// ----------------------------------------------------------------------------
// rss_datapath
// Record store, sort index registers, compare unit and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_datapath
  import rss_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_t              ctrl,
  output status_t                 stat,
  input  wire logic               cfg_write,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [SCORE_W-1:0] score,
  input  wire logic [IDENT_W-1:0] ident,
  input  wire logic               last_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [SCORE_W-1:0]      sorted_score,
  output logic [IDENT_W-1:0]      sorted_ident,
  output logic                    last_out
);

  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  logic [REC_W-1:0] mem [MAX_RECORDS];
  logic [REC_W-1:0] rdata;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [REC_W-1:0] wdata;
  logic             we;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] scan;
  logic [IDX_W-1:0] best;
  logic [IDX_W-1:0] k;
  logic [REC_W-1:0] pos_rec;
  logic [REC_W-1:0] best_rec;
  logic             desc;

  logic             in_xfer;
  logic             better;
  logic [SCORE_W-1:0] rscore;
  logic [SCORE_W-1:0] bscore;

  assign in_stall = (ctrl.op != OP_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign rscore   = rdata[REC_W-1:IDENT_W];
  assign bscore   = best_rec[REC_W-1:IDENT_W];
  assign better   = desc ? (rscore > bscore) : (rscore < bscore);

  always_comb begin
    stat.in_close  = in_xfer && last_in;
    stat.few       = (count < CNT_W'(2));
    stat.scan_more = ((CNT_W'(scan) + CNT_W'(1)) < count);
    stat.pos_more  = ((CNT_W'(pos) + CNT_W'(2)) < count);
    stat.k_more    = ((CNT_W'(k) + CNT_W'(1)) < count);
    stat.out_busy  = out_valid && out_stall;
  end

  always_comb begin
    case (ctrl.op)
      OP_READ_POS:  raddr = pos;
      OP_READ_SCAN: raddr = scan;
      OP_EMIT_READ: raddr = k;
      default:      raddr = pos;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = count[IDX_W-1:0];
    wdata = {score, ident};
    case (ctrl.op)
      OP_LOAD: begin
        we = in_xfer && (count < CNT_W'(MAX_RECORDS));
      end
      OP_WRITE_POS: begin
        we    = 1'b1;
        waddr = pos;
        wdata = best_rec;
      end
      OP_WRITE_BEST: begin
        we    = 1'b1;
        waddr = best;
        wdata = pos_rec;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      desc  <= 1'b0;
    end else begin
      if (cfg_write) begin
        desc <= cfg_data;
      end
      if (ctrl.op == OP_LOAD && in_xfer && count < CNT_W'(MAX_RECORDS)) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.op == OP_CLEAR) begin
        count <= '0;
      end
    end
  end

  // Index and record registers of the sort and the emit index; no reset needed.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INIT: begin
        pos <= '0;
      end
      OP_TAKE_POS: begin
        pos_rec  <= rdata;
        best_rec <= rdata;
        best     <= pos;
        scan     <= pos + IDX_W'(1);
      end
      OP_COMPARE: begin
        if (better) begin
          best     <= scan;
          best_rec <= rdata;
        end
        scan <= scan + IDX_W'(1);
      end
      OP_WRITE_BEST: begin
        pos <= pos + IDX_W'(1);
      end
      OP_EMIT_INIT: begin
        k <= '0;
      end
      OP_EMIT_OUT: begin
        k <= k + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT_OUT) begin
      sorted_score <= rdata[REC_W-1:IDENT_W];
      sorted_ident <= rdata[IDENT_W-1:0];
      last_out     <= ((CNT_W'(k) + CNT_W'(1)) == count);
    end
  end

  // A new result is only loaded into an empty output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EMIT_OUT) |-> !out_valid)
    else $error("output register overwritten before its transfer");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond capacity");

  // The scan always stays past the current position and inside the set.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_COMPARE) |-> ((scan > pos) && (CNT_W'(scan) < count)))
    else $error("scan index out of range");

endmodule

`default_nettype wire

[src/record_selection_sorter.sv]
// Loading takes one record per cycle; records beyond MAX_RECORDS are dropped.
// After the closing transfer the input stalls while the set of n records is
// sorted over the single store read port. The records are then emitted one
// at a time, each read once the output is not stalled and then registered;
// a clear step returns to loading. Reset clears the sequencer, record count,
// sort order and output valid; the store itself is not cleared.
// ----------------------------------------------------------------------------
// record_selection_sorter
// Collects records and emits them ordered by score using selection sort.
// ----------------------------------------------------------------------------
`default_nettype none

module record_selection_sorter
  import rss_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [SCORE_W-1:0] score,
  input  wire logic [IDENT_W-1:0] ident,
  input  wire logic               last_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [SCORE_W-1:0]      sorted_score,
  output logic [IDENT_W-1:0]      sorted_ident,
  output logic                    last_out
);

  ctrl_t   ctrl;
  status_t stat;

  rss_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  rss_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .score        (score),
    .ident        (ident),
    .last_in      (last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_score (sorted_score),
    .sorted_ident (sorted_ident),
    .last_out     (last_out)
  );

endmodule

`default_nettype wire
